>>> rtl/core/pcgx_pkg.sv
// pcgx_pkg: shared types, constants and functions of the PCG32 XSH-RR generator.
// No dependencies; used by the channel interfaces and the generator core.
package pcgx_pkg;

	typedef enum logic {
		OP_NEXT = 1'b0,
		OP_SEED = 1'b1
	} op_t;

	localparam int unsigned  REG_ADDR_W   = 4;
	localparam logic         REG_MULT_IDX = 1'b0;
	localparam logic [63:0]  MULT_RESET   = 64'd6364136223846793005;
	localparam logic [63:0]  STATE_RESET  = MULT_RESET + 64'd1;
	localparam logic [63:0]  INC_RESET    = 64'd1;
	localparam int unsigned  SEED_SHIFT   = 31;

	// 64 x 64 product mod 2^64 from three 32 x 32 partial products
	function automatic logic [63:0] mul64_lo(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p_ll;
		logic [31:0] p_hl;
		logic [31:0] p_lh;
		p_ll = a[31:0] * b[31:0];
		p_hl = 32'(a[63:32] * b[31:0]);
		p_lh = 32'(a[31:0] * b[63:32]);
		return p_ll + {p_hl + p_lh, 32'd0};
	endfunction

	// xorshift high, then rotate right by the top five state bits
	function automatic logic [31:0] xsh_rr(input logic [63:0] s);
		logic [63:0] xs;
		logic [31:0] x;
		logic [4:0]  r;
		logic [63:0] xx;
		xs = (s >> 18) ^ s;
		x  = xs[58:27];
		r  = s[63:59];
		xx = {x, x} >> r;
		return xx[31:0];
	endfunction

endpackage

>>> rtl/core/pcgx_if.sv
// pcgx_in_if / pcgx_out_if: valid-ready channels of the PCG32 generator.
// Depends on pcgx_pkg for the opcode type.
interface pcgx_in_if;
	logic            valid;
	logic            ready;
	pcgx_pkg::op_t   opcode;
	logic [63:0]     seed_value;

	modport source (output valid, output opcode, output seed_value, input ready);
	modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

interface pcgx_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

>>> rtl/core/pcg32_xsh_rr_generator_core.sv
// PCG32 XSH-RR generator core: input register, LCG step, result register.
// Depends on pcgx_pkg and the channel interfaces in pcgx_if.sv.
// A request is taken every clock while no next request waits on an unread result;
// a next request (opcode 0) passes the input and result registers before its word is
// on rsp, a seed request (opcode 1) yields nothing. The rate of one request per cycle
// is set by the state loop, a 64-bit multiply-add of three 32 x 32 partial products.
// The multiplier register sits at byte address 0 of the 64-bit APB port.
module pcg32_xsh_rr_generator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	pcgx_in_if.sink                       req,
	pcgx_out_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pcgx_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready
);

	logic          s1_valid_q;
	pcgx_pkg::op_t op_s1;
	logic [63:0]   inc_seed_s1;
	logic [63:0]   base_s1;
	logic [63:0]   state_q;
	logic [63:0]   inc_q;
	logic [63:0]   mult_q;
	logic          rsp_valid_q;
	logic [31:0]   word_q;

	logic          s1_fire;
	logic          req_fire;
	logic [63:0]   seed_t;
	logic [63:0]   seed_inc;
	logic [63:0]   mul_a;
	logic [63:0]   add_b;
	logic [63:0]   state_next;

	assign pready = 1'b1;
	assign prdata = (paddr[pcgx_pkg::REG_ADDR_W-1] == pcgx_pkg::REG_MULT_IDX) ? mult_q : 64'd0;

	assign s1_fire  = s1_valid_q && (op_s1 == pcgx_pkg::OP_SEED || !rsp_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || s1_fire;
	assign req_fire = req.valid && req.ready;

	assign seed_t   = (req.seed_value << pcgx_pkg::SEED_SHIFT) | req.seed_value;
	assign seed_inc = {seed_t[62:0], 1'b1};

	assign mul_a      = (op_s1 == pcgx_pkg::OP_SEED) ? base_s1 : state_q;
	assign add_b      = (op_s1 == pcgx_pkg::OP_SEED) ? inc_seed_s1 : (inc_q | 64'd1);
	assign state_next = pcgx_pkg::mul64_lo(mul_a, mult_q) + add_b;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.random_word = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= pcgx_pkg::MULT_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[pcgx_pkg::REG_ADDR_W-1] == pcgx_pkg::REG_MULT_IDX) begin
			mult_q <= pwdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_s1       <= req.opcode;
			inc_seed_s1 <= seed_inc;
			base_s1     <= seed_t + seed_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			state_q     <= pcgx_pkg::STATE_RESET;
			inc_q       <= pcgx_pkg::INC_RESET;
		end else begin
			if (req_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				state_q <= state_next;
				if (op_s1 == pcgx_pkg::OP_SEED) begin
					inc_q <= inc_seed_s1;
				end
			end
			if (s1_fire && op_s1 == pcgx_pkg::OP_NEXT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && op_s1 == pcgx_pkg::OP_NEXT) begin
			word_q <= pcgx_pkg::xsh_rr(state_q);
		end
	end

	a_inc_odd: assert property (@(posedge clk) disable iff (!arst_n) inc_q[0])
		else $error("stream increment lost its low bit");

	a_next_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && op_s1 == pcgx_pkg::OP_NEXT |=> rsp_valid_q)
		else $error("next request produced no result");

	a_next_word: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && op_s1 == pcgx_pkg::OP_NEXT |=> word_q == pcgx_pkg::xsh_rr($past(state_q)))
		else $error("result word not taken from pre-advance state");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_fire |=> s1_valid_q && $stable(state_q) && $stable(inc_q))
		else $error("stalled request changed generator state");

endmodule

>>> bench/pcgx_checker.sv
// pcgx_checker: watches the request, result and register channels of the PCG32 core,
// predicts every random word and compares it with the one the core returns.
// Depends on pcgx_pkg and the channel interfaces in pcgx_if.sv.
module pcgx_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	pcgx_in_if                              req,
	pcgx_out_if                             rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pcgx_pkg::REG_ADDR_W-1:0] paddr,
	input  logic [63:0]                     pwdata,
	input  logic                            pready,
	output int unsigned                     words_pending,
	output int unsigned                     error_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0] mult_q;
	logic [63:0] state_q;
	logic [63:0] incr_q;
	logic [31:0] expected_words[$];
	int unsigned mismatches;

	function automatic logic [31:0] permute_word(input logic [63:0] s);
		logic [63:0] mixed;
		logic [31:0] x;
		logic [4:0]  rot;
		mixed = s ^ (s >> 18);
		x     = mixed[58:27];
		rot   = s[63:59];
		return (x >> rot) | (x << (6'd32 - rot));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] folded;
		logic [31:0] want;
		if (!arst_n) begin
			mult_q  = pcgx_pkg::MULT_RESET;
			incr_q  = 64'd1;
			state_q = pcgx_pkg::MULT_RESET + 64'd1;
			expected_words.delete();
			mismatches = 0;
			words_pending <= 0;
			error_count   <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_words.size() == 0) begin
					$error("random_word: expected none, actual %h", rsp.random_word);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (rsp.random_word !== want) begin
						$error("random_word: expected %h, actual %h", want, rsp.random_word);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.opcode == pcgx_pkg::OP_SEED) begin
					folded  = (req.seed_value << pcgx_pkg::SEED_SHIFT) | req.seed_value;
					incr_q  = {folded[62:0], 1'b1};
					state_q = (folded + incr_q) * mult_q + incr_q;
				end else begin
					expected_words.push_back(permute_word(state_q));
					state_q = state_q * mult_q + (incr_q | 64'd1);
				end
			end
			if (psel && penable && pwrite && pready
					&& (paddr >> 3) == pcgx_pkg::REG_ADDR_W'(pcgx_pkg::REG_MULT_IDX))
				mult_q = pwdata;
			words_pending <= expected_words.size();
			error_count   <= mismatches;
		end
	end

endmodule

>>> bench/tb_pcg32_xsh_rr_generator_core.sv
// tb_pcg32_xsh_rr_generator_core: drives seed and next requests, multiplier writes and
// receiver stalls into the PCG32 core; pcgx_checker does the prediction and comparison.
// Depends on pcgx_pkg, pcgx_if.sv, the core and bench/pcgx_checker.sv.
module tb_pcg32_xsh_rr_generator_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS  = 125;
	localparam logic [pcgx_pkg::REG_ADDR_W-1:0] MULT_ADDR =
		pcgx_pkg::REG_ADDR_W'(pcgx_pkg::REG_MULT_IDX) << 3;
	localparam logic [pcgx_pkg::REG_ADDR_W-1:0] SPARE_ADDR =
		MULT_ADDR + pcgx_pkg::REG_ADDR_W'(8);

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [pcgx_pkg::REG_ADDR_W-1:0] paddr;
	logic [63:0]                     pwdata;
	logic [63:0]                     prdata;
	logic                            pready;
	int unsigned                     words_pending;
	int unsigned                     error_count;
	bit                              idling;
	bit                              hold_pending;

	pcgx_in_if  req_ch ();
	pcgx_out_if rsp_ch ();

	pcg32_xsh_rr_generator_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pcgx_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.words_pending (words_pending),
		.error_count   (error_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ch.ready <= !(idling && $urandom_range(99) < 8);
			end
		end
	end

	function automatic logic [63:0] pick_seed();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_request(input pcgx_pkg::op_t op, input logic [63:0] seed);
		if (idling && $urandom_range(99) < 8) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.seed_value <= seed;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(99) < 12)
				send_request(pcgx_pkg::OP_SEED, pick_seed());
			else
				send_request(pcgx_pkg::OP_NEXT, {$urandom, $urandom});
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (words_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pcgx_pkg::REG_ADDR_W-1:0] addr,
			input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.opcode     <= pcgx_pkg::OP_NEXT;
		req_ch.seed_value <= '0;
		idling       = 1'b1;
		hold_pending = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state, then edge seeds
		send_request(pcgx_pkg::OP_NEXT, '0);
		send_request(pcgx_pkg::OP_NEXT, '1);
		send_request(pcgx_pkg::OP_NEXT, '0);
		send_request(pcgx_pkg::OP_SEED, 64'd0);
		send_request(pcgx_pkg::OP_NEXT, '0);
		send_request(pcgx_pkg::OP_NEXT, '0);
		send_request(pcgx_pkg::OP_SEED, '1);
		send_request(pcgx_pkg::OP_NEXT, '0);
		send_request(pcgx_pkg::OP_SEED, 64'd1);
		send_request(pcgx_pkg::OP_NEXT, '1);
		send_request(pcgx_pkg::OP_SEED, 64'h8000_0000_0000_0000);
		send_request(pcgx_pkg::OP_NEXT, '0);
		send_request(pcgx_pkg::OP_SEED, 64'h5555_5555_5555_5555);
		send_request(pcgx_pkg::OP_NEXT, '0);
		send_request(pcgx_pkg::OP_SEED, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(pcgx_pkg::OP_NEXT, '0);
		send_request(pcgx_pkg::OP_SEED, 64'h0123_4567_89AB_CDEF);
		send_request(pcgx_pkg::OP_SEED, 64'hFEDC_BA98_7654_3210);
		send_request(pcgx_pkg::OP_NEXT, '0);
		run_random(PHASE_ITEMS);
		settle();

		// zero multiplier: seed zero leaves a state with no rotation
		write_reg(MULT_ADDR, 64'd0);
		send_request(pcgx_pkg::OP_SEED, 64'd0);
		send_request(pcgx_pkg::OP_NEXT, '0);
		send_request(pcgx_pkg::OP_NEXT, '0);
		send_request(pcgx_pkg::OP_SEED, '1);
		send_request(pcgx_pkg::OP_NEXT, '0);
		run_random(PHASE_ITEMS);
		settle();

		write_reg(MULT_ADDR, '1);
		idling = 1'b0;
		run_random(PHASE_ITEMS);
		settle();
		idling = 1'b1;

		write_reg(MULT_ADDR, 64'd1);
		write_reg(SPARE_ADDR, {$urandom, $urandom});
		hold_pending = 1'b1;
		run_random(PHASE_ITEMS);
		settle();

		write_reg(MULT_ADDR, {$urandom, $urandom} & ~64'd1);
		run_random(PHASE_ITEMS);
		settle();

		write_reg(MULT_ADDR, pcgx_pkg::MULT_RESET);
		run_random(PHASE_ITEMS);
		settle();

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/pcgx_pkg.sv
rtl/core/pcgx_if.sv
rtl/core/pcg32_xsh_rr_generator_core.sv
bench/pcgx_checker.sv
bench/tb_pcg32_xsh_rr_generator_core.sv
